// ===== rtl/c2p_pkg.sv =====
package c2p_pkg;

    // Field widths
    localparam int XyW     = 16;
    localparam int RadW    = 16;
    localparam int AngW    = 15;
    localparam int DistW   = 17;
    localparam int DiffW   = 16;

    // CORDIC angle arithmetic, angle units of 2^-14 degree
    localparam int TableLen        = 24;
    localparam int AngShift        = 14;
    localparam int GuardBits       = 8;
    localparam int HalfTurnDeg     = 180;
    localparam int FullTurn64      = 2 * HalfTurnDeg * 64;
    localparam int DefCordicStages = 16;
    localparam int ZW              = 25;
    localparam int CW              = 27;

    // Square root pipeline
    localparam int SqInW   = 34;
    localparam int SqSteps = 17;
    localparam int SqLat   = SqSteps + 3;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_REF_X = 1'b0,
        REG_REF_Y = 1'b1
    } t_cfg_idx;

    // atan(2^-i) in units of 2^-14 degree
    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:  v = 25'sd737280;
            1:  v = 25'sd435242;
            2:  v = 25'sd229970;
            3:  v = 25'sd116736;
            4:  v = 25'sd58595;
            5:  v = 25'sd29326;
            6:  v = 25'sd14667;
            7:  v = 25'sd7334;
            8:  v = 25'sd3667;
            9:  v = 25'sd1833;
            10: v = 25'sd917;
            11: v = 25'sd458;
            12: v = 25'sd229;
            13: v = 25'sd115;
            14: v = 25'sd57;
            15: v = 25'sd29;
            16: v = 25'sd14;
            17: v = 25'sd7;
            18: v = 25'sd4;
            19: v = 25'sd2;
            20: v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/c2p_pt_if.sv =====
interface c2p_pt_if
    import c2p_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic signed [XyW-1:0] x_coord;
    logic signed [XyW-1:0] y_coord;

    modport source (output valid, x_coord, y_coord, input ready);
    modport sink   (input valid, x_coord, y_coord, output ready);
endinterface

// ===== rtl/c2p_res_if.sv =====
interface c2p_res_if
    import c2p_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic        [RadW-1:0]  radius;
    logic        [AngW-1:0]  angle;
    logic        [DistW-1:0] ref_distance;
    logic signed [DiffW-1:0] angle_diff;

    modport source (output valid, radius, angle, ref_distance, angle_diff, input ready);
    modport sink   (input valid, radius, angle, ref_distance, angle_diff, output ready);
endinterface

// ===== rtl/c2p_cordic.sv =====
module c2p_cordic
    import c2p_pkg::*;
#(
    parameter int STAGES = DefCordicStages,
    parameter int DELAY  = 0
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [XyW-1:0] i_x,
    input  logic signed [XyW-1:0] i_y,
    output logic        [AngW-1:0] o_angle
);
    localparam int N = (STAGES < TableLen) ? STAGES : TableLen;
    localparam logic signed [ZW-1:0] HalfTurnZ = ZW'(HalfTurnDeg) <<< AngShift;
    localparam logic signed [ZW-1:0] FullTurnZ = ZW'(2 * HalfTurnDeg) <<< AngShift;
    localparam logic signed [ZW-1:0] RoundZ    = ZW'(1) <<< (AngShift - 7);

    logic signed [CW-1:0] r_cx [0:N];
    logic signed [CW-1:0] r_cy [0:N];
    logic signed [ZW-1:0] r_z  [0:N];
    logic                 r_yz [0:N];
    logic                 r_xz [0:N];
    logic                 r_xn [0:N];
    logic                 r_yp [0:N];
    logic [AngW-1:0]      r_ang;

    logic signed [CW-1:0] n_cx, n_cy;
    logic signed [ZW-1:0] w_zw, w_q;
    logic [AngW-1:0]      n_ang;

    // Add guard bits and fold the left half plane onto the right
    always_comb begin
        n_cx = CW'(i_x) <<< GuardBits;
        n_cy = CW'(i_y) <<< GuardBits;
        if (i_x < 0) begin
            n_cx = -n_cx;
            n_cy = -n_cy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= n_cx;
            r_cy[0] <= n_cy;
            r_z[0]  <= (i_x < 0) ? HalfTurnZ : '0;
            r_yz[0] <= (i_y == 0);
            r_xz[0] <= (i_x == 0);
            r_xn[0] <= (i_x < 0);
            r_yp[0] <= (i_y > 0);
        end
    end

    // One rotation per stage
    for (genvar i = 0; i < N; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_cy[i] > 0) begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_z[i+1]  <= r_z[i] + atan_entry(i);
                end else begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_z[i+1]  <= r_z[i] - atan_entry(i);
                end
                r_yz[i+1] <= r_yz[i];
                r_xz[i+1] <= r_xz[i];
                r_xn[i+1] <= r_xn[i];
                r_yp[i+1] <= r_yp[i];
            end
        end
    end

    // Wrap, round to 1/64 degree and apply the axis cases
    always_comb begin
        w_zw = (r_z[N] < 0) ? r_z[N] + FullTurnZ : r_z[N];
        w_q  = (w_zw + RoundZ) >>> (AngShift - 6);
        if (w_q >= ZW'(FullTurn64)) begin
            w_q = w_q - ZW'(FullTurn64);
        end
        if (r_yz[N]) begin
            n_ang = r_xn[N] ? AngW'(HalfTurnDeg * 64) : '0;
        end else if (r_xz[N]) begin
            n_ang = r_yp[N] ? AngW'(HalfTurnDeg * 32) : AngW'(HalfTurnDeg * 96);
        end else begin
            n_ang = w_q[AngW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= n_ang;
        end
    end

    // Align with the longer unit
    if (DELAY == 0) begin : g_nodly
        assign o_angle = r_ang;
    end else begin : g_dly
        logic [AngW-1:0] r_dly [0:DELAY-1];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dly[0] <= r_ang;
                for (int k = 1; k < DELAY; k++) begin
                    r_dly[k] <= r_dly[k-1];
                end
            end
        end
        assign o_angle = r_dly[DELAY-1];
    end
endmodule

// ===== rtl/c2p_sqrt.sv =====
module c2p_sqrt
    import c2p_pkg::*;
#(
    parameter int DELAY = 0
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [DistW-1:0] i_a,
    input  logic signed [DistW-1:0] i_b,
    output logic        [DistW-1:0] o_root
);
    logic [SqInW-1:0] r_sa, r_sb;
    logic [SqInW-1:0] r_n   [0:SqSteps];
    logic [SqInW-1:0] r_res [0:SqSteps];
    logic [DistW-1:0] r_root;

    logic signed [SqInW-1:0] w_pa, w_pb;

    // Form the squares at full product width
    assign w_pa = i_a * i_a;
    assign w_pb = i_b * i_b;

    // Square both terms, then sum them
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sa     <= $unsigned(w_pa);
            r_sb     <= $unsigned(w_pb);
            r_n[0]   <= r_sa + r_sb;
            r_res[0] <= '0;
        end
    end

    // One result bit per stage, restoring method
    for (genvar k = 0; k < SqSteps; k++) begin : g_step
        localparam logic [SqInW-1:0] Bit = SqInW'(1) << (2 * (SqSteps - 1 - k));
        logic [SqInW-1:0] w_t;
        assign w_t = r_res[k] + Bit;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_n[k] >= w_t) begin
                    r_n[k+1]   <= r_n[k] - w_t;
                    r_res[k+1] <= (r_res[k] >> 1) + Bit;
                end else begin
                    r_n[k+1]   <= r_n[k];
                    r_res[k+1] <= r_res[k] >> 1;
                end
            end
        end
    end

    // Round to nearest: the remainder is v - res^2
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root <= (r_n[SqSteps] > r_res[SqSteps]) ? DistW'(r_res[SqSteps] + 1'b1)
                                                      : DistW'(r_res[SqSteps]);
        end
    end

    if (DELAY == 0) begin : g_nodly
        assign o_root = r_root;
    end else begin : g_dly
        logic [DistW-1:0] r_dly [0:DELAY-1];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dly[0] <= r_root;
                for (int k = 1; k < DELAY; k++) begin
                    r_dly[k] <= r_dly[k-1];
                end
            end
        end
        assign o_root = r_dly[DELAY-1];
    end
endmodule

// ===== rtl/cartesian_to_polar_degrees_core.sv =====
// Channel   Dir  Fields
// i_pt      in   x_coord, y_coord (signed Q8.8)
// o_res     out  radius, angle, ref_distance, angle_diff
// i_cfg_*   in   write port: 0 ref_x, 1 ref_y
//
// One item enters per cycle while o_res is not stalled; the output register follows
// the longer of the 17-step square root pipeline and the CORDIC rotation stages.
// The reference point runs through its own CORDIC lane next to each item.
// Synchronous active-low reset clears the valid bits and the reference point.
// A stall on o_res freezes every stage at once; nothing is lost or repeated.
module cartesian_to_polar_degrees_core
    import c2p_pkg::*;
#(
    parameter int CORDIC_STAGES = DefCordicStages
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    c2p_pt_if.sink         i_pt,
    c2p_res_if.source      o_res,
    input  logic           i_cfg_we,
    input  logic [0:0]     i_cfg_idx,
    input  logic [XyW-1:0] i_cfg_data
);
    localparam int N    = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;
    localparam int CLat = N + 2;
    localparam int L    = (CLat > SqLat) ? CLat : SqLat;

    logic signed [XyW-1:0] r_ref_x, r_ref_y;
    logic                  r_v [0:L-1];
    logic                  r_out_valid;
    logic [RadW-1:0]       r_radius;
    logic [AngW-1:0]       r_angle;
    logic [DistW-1:0]      r_dist;
    logic signed [DiffW-1:0] r_diff;

    logic                  w_en;
    logic [AngW-1:0]       w_ang, w_rang;
    logic [DistW-1:0]      w_rad, w_dist;
    logic signed [DistW-1:0] w_dx, w_dy;

    assign w_en       = !r_out_valid || o_res.ready;
    assign i_pt.ready = w_en;

    // Hold the reference point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= '0;
            r_ref_y <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_REF_X: r_ref_x <= i_cfg_data;
                REG_REF_Y: r_ref_y <= i_cfg_data;
            endcase
        end
    end

    assign w_dx = DistW'(i_pt.x_coord) - DistW'(r_ref_x);
    assign w_dy = DistW'(i_pt.y_coord) - DistW'(r_ref_y);

    c2p_cordic #(.STAGES(CORDIC_STAGES), .DELAY(L - CLat)) u_cordic_pt (
        .i_clk(i_clk), .i_en(w_en), .i_x(i_pt.x_coord), .i_y(i_pt.y_coord),
        .o_angle(w_ang)
    );

    c2p_cordic #(.STAGES(CORDIC_STAGES), .DELAY(L - CLat)) u_cordic_ref (
        .i_clk(i_clk), .i_en(w_en), .i_x(r_ref_x), .i_y(r_ref_y),
        .o_angle(w_rang)
    );

    c2p_sqrt #(.DELAY(L - SqLat)) u_sqrt_rad (
        .i_clk(i_clk), .i_en(w_en),
        .i_a(DistW'(i_pt.x_coord)), .i_b(DistW'(i_pt.y_coord)),
        .o_root(w_rad)
    );

    c2p_sqrt #(.DELAY(L - SqLat)) u_sqrt_dist (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_dx), .i_b(w_dy),
        .o_root(w_dist)
    );

    // Advance the valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_pt.valid;
            for (int k = 1; k < L; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_out_valid <= r_v[L-1];
        end
    end

    // Output register, angle difference formed here
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_radius <= w_rad[RadW-1:0];
            r_angle  <= w_ang;
            r_dist   <= w_dist;
            r_diff   <= DiffW'(w_ang) - DiffW'(w_rang);
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.radius       = r_radius;
    assign o_res.angle        = r_angle;
    assign o_res.ref_distance = r_dist;
    assign o_res.angle_diff   = r_diff;

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_res.valid)
        else $error("output valid after reset");
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.angle < AngW'(FullTurn64)))
        else $error("angle out of range");
    a_radius_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.radius <= 16'd46341))
        else $error("radius out of range");
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(r_diff)))
        else $error("result lost in stall");
endmodule
